>>> design/link_connect_retry_fsm_defines.svh
// ---------------------------------------------------------------------------
// Link connection manager assertion macros
// Concurrent assertion forms, included by the design files and used in the core.
// ---------------------------------------------------------------------------
`ifndef LINK_CONNECT_RETRY_FSM_DEFINES_SVH
`define LINK_CONNECT_RETRY_FSM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link manager assertion failed");

// Next-cycle implication, disabled during reset.
`define LCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link manager assertion failed");

`endif

>>> design/lcr_pkg.sv
// ---------------------------------------------------------------------------
// Link connection manager package
// Types, codes and constants shared by the link connection manager files.
// ---------------------------------------------------------------------------
package lcr_pkg;

   localparam int MAX_NETWORKS = 8;
   localparam logic [15:0] DEFAULT_INTERVAL = 16'd500;
   localparam logic [7:0] DEFAULT_RETRIES = 8'd5;
   localparam logic [3:0] MAX_NET_COUNT = 4'(MAX_NETWORKS);

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_CONNECTING = 2'd1,
      PH_CONNECTED  = 2'd2,
      PH_ERROR      = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_IDLE       = 3'd1,
      EV_CONNECTING = 3'd2,
      EV_CONNECTED  = 3'd3,
      EV_LOST       = 3'd4,
      EV_ERROR      = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_BEGIN = 2'd1,
      MODE_END   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REG_NETWORK_COUNT  = 2'd0,
      REG_RETRY_INTERVAL = 2'd1,
      REG_MAX_RETRIES    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  network_count;
      logic [15:0] retry_interval;
      logic [7:0]  max_retries;
   } cfg_type;

   typedef struct packed {
      logic [1:0] link_state;
      logic       attempt;
      logic [2:0] net_index;
      logic [2:0] event_res;
      logic       drop_link;
   } result_type;

endpackage

>>> design/lcr_csr.sv
// ---------------------------------------------------------------------------
// Link connection manager configuration registers
// APB-style register file holding network count, retry interval and retries.
// ---------------------------------------------------------------------------
module lcr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output lcr_pkg::cfg_type  cfg
);

   logic [3:0]  network_count_ff;
   logic [15:0] retry_interval_ff;
   logic [7:0]  max_retries_ff;
   logic        write_en;
   logic [1:0]  reg_sel;

   assign write_en = psel && penable && pwrite;
   assign reg_sel  = paddr[3:2];
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         network_count_ff  <= 4'd0;
         retry_interval_ff <= lcr_pkg::DEFAULT_INTERVAL;
         max_retries_ff    <= lcr_pkg::DEFAULT_RETRIES;
      end else if (write_en) begin
         case (reg_sel)
            lcr_pkg::REG_NETWORK_COUNT:  network_count_ff  <= pwdata[3:0];
            lcr_pkg::REG_RETRY_INTERVAL: retry_interval_ff <= pwdata[15:0];
            lcr_pkg::REG_MAX_RETRIES:    max_retries_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         lcr_pkg::REG_NETWORK_COUNT:  prdata = {28'd0, network_count_ff};
         lcr_pkg::REG_RETRY_INTERVAL: prdata = {16'd0, retry_interval_ff};
         lcr_pkg::REG_MAX_RETRIES:    prdata = {24'd0, max_retries_ff};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg.network_count  = network_count_ff;
   assign cfg.retry_interval = retry_interval_ff;
   assign cfg.max_retries    = max_retries_ff;

endmodule

>>> design/lcr_core.sv
// ---------------------------------------------------------------------------
// Link connection manager core
// Phase state machine with wait counter, retry counter and network rotation.
// ---------------------------------------------------------------------------
`include "link_connect_retry_fsm_defines.svh"

module lcr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           mode,
   input  logic                 link_up,
   input  lcr_pkg::cfg_type     cfg,
   output lcr_pkg::result_type  result
);

   lcr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  retry_ff, retry_in;
   logic [2:0]  net_ff, net_in;
   logic [3:0]  active_cnt;
   logic [8:0]  retry_next;
   logic [3:0]  net_next;
   logic        attempt;
   logic        drop;
   lcr_pkg::event_type ev;

   // Counts above the supported number of networks are clamped.
   assign active_cnt = (cfg.network_count > lcr_pkg::MAX_NET_COUNT) ?
                       lcr_pkg::MAX_NET_COUNT : cfg.network_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lcr_pkg::PH_IDLE;
         wait_ff  <= 16'd0;
         retry_ff <= 8'd0;
         net_ff   <= 3'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         retry_ff <= retry_in;
         net_ff   <= net_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      retry_in   = retry_ff;
      net_in     = net_ff;
      attempt    = 1'b0;
      drop       = 1'b0;
      ev         = lcr_pkg::EV_NONE;
      // The incremented retry count is one bit wider so that 255 retries work.
      retry_next = {1'b0, retry_ff} + 9'd1;
      net_next   = {1'b0, net_ff};
      if (retry_next > {1'b0, cfg.max_retries}) begin
         retry_next = 9'd1;
         net_next   = net_next + 4'd1;
      end
      if (net_next >= active_cnt) begin
         net_next = 4'd0;
      end

      case (mode)
         lcr_pkg::MODE_BEGIN: begin
            if (phase_ff == lcr_pkg::PH_IDLE) begin
               if (active_cnt == 4'd0) begin
                  phase_in = lcr_pkg::PH_ERROR;
                  ev       = lcr_pkg::EV_ERROR;
               end else begin
                  phase_in = lcr_pkg::PH_CONNECTING;
                  wait_in  = 16'd0;
                  retry_in = 8'd0;
                  net_in   = 3'd0;
                  ev       = lcr_pkg::EV_CONNECTING;
               end
            end
         end
         lcr_pkg::MODE_END: begin
            phase_in = lcr_pkg::PH_IDLE;
            ev       = lcr_pkg::EV_IDLE;
            drop     = 1'b1;
         end
         lcr_pkg::MODE_TICK: begin
            case (phase_ff)
               lcr_pkg::PH_CONNECTING: begin
                  if (link_up) begin
                     phase_in = lcr_pkg::PH_CONNECTED;
                     ev       = lcr_pkg::EV_CONNECTED;
                  end else if (wait_ff == 16'd0) begin
                     if (active_cnt == 4'd0) begin
                        phase_in = lcr_pkg::PH_ERROR;
                        ev       = lcr_pkg::EV_ERROR;
                     end else begin
                        retry_in = retry_next[7:0];
                        net_in   = net_next[2:0];
                        wait_in  = cfg.retry_interval;
                        attempt  = 1'b1;
                     end
                  end else begin
                     wait_in = wait_ff - 16'd1;
                  end
               end
               lcr_pkg::PH_CONNECTED: begin
                  if (!link_up) begin
                     if (active_cnt == 4'd0) begin
                        phase_in = lcr_pkg::PH_ERROR;
                        ev       = lcr_pkg::EV_ERROR;
                     end else begin
                        phase_in = lcr_pkg::PH_CONNECTING;
                        wait_in  = 16'd0;
                        retry_in = 8'd0;
                        net_in   = 3'd0;
                        ev       = lcr_pkg::EV_LOST;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign result.link_state = phase_in;
   assign result.attempt    = attempt;
   assign result.net_index  = net_in;
   assign result.event_res  = ev;
   assign result.drop_link  = drop;

   // An attempt always reloads the wait counter from the interval register.
   `LCR_ASSERT_NEXT(a_attempt_reload, clock, reset, step && attempt,
      wait_ff == $past(cfg.retry_interval))
   // After an attempt the selected network lies inside the configured range.
   `LCR_ASSERT_NEXT(a_attempt_net_range, clock, reset, step && attempt,
      {1'b0, net_ff} < $past(active_cnt))
   // Attempts only come from the connecting phase and never with a disconnect.
   `LCR_ASSERT_NOW(a_attempt_phase, clock, reset, attempt,
      phase_ff == lcr_pkg::PH_CONNECTING && phase_in == lcr_pkg::PH_CONNECTING && !drop)

endmodule

>>> design/link_connect_retry_fsm.sv
// ---------------------------------------------------------------------------
// Link connection manager
// Connect, retry and network rotation state machine with APB configuration.
// ---------------------------------------------------------------------------
// The block accepts one transaction every clock cycle while req_stall is low
// and returns exactly one result transaction for each: the transaction waits
// in the input register, then the state update logic writes the result
// register. Throughput is set by that single-pass update between the two
// registers. Configure registers only while no transaction is in flight.
`include "link_connect_retry_fsm_defines.svh"

module link_connect_retry_fsm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic        req_link_up,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_link_state,
   output logic        rsp_attempt,
   output logic [2:0]  rsp_net_index,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_drop_link,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   lcr_pkg::cfg_type    cfg;
   lcr_pkg::result_type step_result;
   lcr_pkg::result_type out_res_ff;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_mode_ff;
   logic       in_link_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;
   logic       move;
   logic       accept;

   lcr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lcr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (move),
      .mode    (in_mode_ff),
      .link_up (in_link_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // The result register can take a new transaction when empty or draining.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff <= req_mode;
         in_link_ff <= req_link_up;
      end
      if (move) begin
         out_res_ff <= step_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_link_state = out_res_ff.link_state;
   assign rsp_attempt    = out_res_ff.attempt;
   assign rsp_net_index  = out_res_ff.net_index;
   assign rsp_event_res  = out_res_ff.event_res;
   assign rsp_drop_link  = out_res_ff.drop_link;

endmodule

>>> verif/tb_link_connect_retry_fsm.sv
// ---------------------------------------------------------------------------
// Link connection manager testbench
// Drives begin, end, tick and spare-mode transactions into the connection
// manager, predicts results from a cycle-free model of the state machine
// or takes them from the script, and compares the results field by field.
// Registers are rewritten between phases over APB and read back.
// ---------------------------------------------------------------------------
module tb_link_connect_retry_fsm;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int SCRIPT_ROWS = 32;

   typedef struct {
      logic                   is_cfg;
      lcr_pkg::reg_index_type csr_idx;
      logic [31:0]            value;
      logic [1:0]             mode;
      logic                   up;
      logic                   typed;
      lcr_pkg::result_type    res;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic        req_link_up;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_link_state;
   logic        rsp_attempt;
   logic [2:0]  rsp_net_index;
   logic [2:0]  rsp_event_res;
   logic        rsp_drop_link;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Predicted state of the connection manager and its registers.
   lcr_pkg::phase_type st_phase;
   logic [15:0] st_wait;
   int          st_tries;
   int          st_net;
   logic [3:0]  cfg_nets;
   logic [15:0] cfg_interval;
   logic [7:0]  cfg_retries;

   lcr_pkg::result_type expected_q[$];
   int          check_errors = 0;
   int          csr_errors = 0;
   int unsigned cycle_count = 0;
   int          send_gap_pct = 7;
   int          recv_stall_pct = 55;
   int          hold_requests = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   script_row_type script [SCRIPT_ROWS];

   link_connect_retry_fsm uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_link_up(req_link_up),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_link_state(rsp_link_state),
      .rsp_attempt(rsp_attempt),
      .rsp_net_index(rsp_net_index),
      .rsp_event_res(rsp_event_res),
      .rsp_drop_link(rsp_drop_link),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= 80;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      lcr_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result transaction with no expectation pending");
            check_errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_link_state !== want.link_state) begin
               $error("link_state: expected %0d, got %0d", want.link_state, rsp_link_state);
               check_errors++;
            end
            if (rsp_attempt !== want.attempt) begin
               $error("attempt: expected %0d, got %0d", want.attempt, rsp_attempt);
               check_errors++;
            end
            if (rsp_net_index !== want.net_index) begin
               $error("net_index: expected %0d, got %0d", want.net_index, rsp_net_index);
               check_errors++;
            end
            if (rsp_event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_event_res);
               check_errors++;
            end
            if (rsp_drop_link !== want.drop_link) begin
               $error("drop_link: expected %0d, got %0d", want.drop_link, rsp_drop_link);
               check_errors++;
            end
         end
      end
   end

   function automatic int active_nets();
      return (cfg_nets > lcr_pkg::MAX_NETWORKS) ? lcr_pkg::MAX_NETWORKS : int'(cfg_nets);
   endfunction

   function automatic lcr_pkg::event_type open_session();
      if (active_nets() == 0) begin
         st_phase = lcr_pkg::PH_ERROR;
         return lcr_pkg::EV_ERROR;
      end
      st_phase = lcr_pkg::PH_CONNECTING;
      st_wait = '0;
      st_tries = 0;
      st_net = 0;
      return lcr_pkg::EV_CONNECTING;
   endfunction

   // Advances the predicted state by one transaction and returns its result.
   function automatic lcr_pkg::result_type link_step(input logic [1:0] m, input logic up);
      lcr_pkg::result_type r;
      lcr_pkg::event_type  ev;
      logic       att;
      logic       drop;
      int         tries;
      ev = lcr_pkg::EV_NONE;
      att = 1'b0;
      drop = 1'b0;
      case (m)
         lcr_pkg::MODE_BEGIN: begin
            if (st_phase == lcr_pkg::PH_IDLE) ev = open_session();
         end
         lcr_pkg::MODE_END: begin
            st_phase = lcr_pkg::PH_IDLE;
            ev = lcr_pkg::EV_IDLE;
            drop = 1'b1;
         end
         lcr_pkg::MODE_TICK: begin
            if (st_phase == lcr_pkg::PH_CONNECTING) begin
               if (up) begin
                  st_phase = lcr_pkg::PH_CONNECTED;
                  ev = lcr_pkg::EV_CONNECTED;
               end else if (st_wait == 0) begin
                  if (active_nets() == 0) begin
                     st_phase = lcr_pkg::PH_ERROR;
                     ev = lcr_pkg::EV_ERROR;
                  end else begin
                     // The count is compared before it is stored, so 255 retries work.
                     tries = st_tries + 1;
                     if (tries > int'(cfg_retries)) begin
                        st_net = st_net + 1;
                        tries = 1;
                     end
                     if (st_net >= active_nets()) st_net = 0;
                     st_tries = tries;
                     att = 1'b1;
                     st_wait = cfg_interval;
                  end
               end else begin
                  st_wait = st_wait - 16'd1;
               end
            end else if (st_phase == lcr_pkg::PH_CONNECTED && !up) begin
               ev = open_session();
               if (ev == lcr_pkg::EV_CONNECTING) ev = lcr_pkg::EV_LOST;
            end
         end
         default: ;
      endcase
      r.link_state = st_phase;
      r.attempt = att;
      r.net_index = 3'(st_net);
      r.event_res = ev;
      r.drop_link = drop;
      return r;
   endfunction

   function automatic lcr_pkg::result_type outcome(input lcr_pkg::phase_type ph,
                                                   input logic att,
                                                   input logic [2:0] net,
                                                   input lcr_pkg::event_type ev,
                                                   input logic drop);
      lcr_pkg::result_type r;
      r.link_state = ph;
      r.attempt = att;
      r.net_index = net;
      r.event_res = ev;
      r.drop_link = drop;
      return r;
   endfunction

   function automatic script_row_type tx_exp(input logic [1:0] m, input logic up,
                                             input logic typed,
                                             input lcr_pkg::result_type res);
      script_row_type r;
      r.is_cfg = 1'b0;
      r.csr_idx = lcr_pkg::REG_NETWORK_COUNT;
      r.value = '0;
      r.mode = m;
      r.up = up;
      r.typed = typed;
      r.res = res;
      return r;
   endfunction

   function automatic script_row_type tx(input logic [1:0] m, input logic up);
      return tx_exp(m, up, 1'b0, '0);
   endfunction

   function automatic script_row_type csr(input lcr_pkg::reg_index_type idx,
                                          input logic [31:0] val);
      script_row_type r;
      r = tx(lcr_pkg::MODE_TICK, 1'b0);
      r.is_cfg = 1'b1;
      r.csr_idx = idx;
      r.value = val;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic [1:0] m, input logic up,
                            input logic typed, input lcr_pkg::result_type res);
      lcr_pkg::result_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_link_up <= up;
      do @(posedge clock); while (req_stall);
      predicted = link_step(m, up);
      expected_q.push_back(typed ? res : predicted);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes one register, reads it back, and updates the predicted registers.
   task automatic write_reg(input lcr_pkg::reg_index_type idx, input logic [31:0] val);
      drain_results();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 4'(idx) * 4'd4;
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== val) begin
         $error("register %0d readback: expected %0d, got %0d", idx, val, prdata);
         csr_errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         lcr_pkg::REG_NETWORK_COUNT:  cfg_nets = val[3:0];
         lcr_pkg::REG_RETRY_INTERVAL: cfg_interval = val[15:0];
         lcr_pkg::REG_MAX_RETRIES:    cfg_retries = val[7:0];
         default: ;
      endcase
   endtask

   initial begin
      int unsigned phase_cfg [RANDOM_PHASES][3];
      int          sent;
      int          len;
      logic        up;
      logic        paused;

      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = lcr_pkg::MODE_TICK;
      req_link_up = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      paused = 1'b0;

      st_phase = lcr_pkg::PH_IDLE;
      st_wait = '0;
      st_tries = 0;
      st_net = 0;
      cfg_nets = '0;
      cfg_interval = lcr_pkg::DEFAULT_INTERVAL;
      cfg_retries = lcr_pkg::DEFAULT_RETRIES;

      // Network count, retry interval, max retries for each random phase.
      phase_cfg = '{'{3, 2, 2}, '{1, 0, 0}, '{15, 1, 255},
                    '{0, 3, 1}, '{2, 65535, 3}, '{8, 0, 1}};

      script = '{
         // Registers still at reset: no networks, so begin goes to error.
         tx_exp(lcr_pkg::MODE_TICK, 1'b0, 1'b1,
                outcome(lcr_pkg::PH_IDLE, 1'b0, 3'd0, lcr_pkg::EV_NONE, 1'b0)),
         tx_exp(lcr_pkg::MODE_TICK, 1'b1, 1'b1,
                outcome(lcr_pkg::PH_IDLE, 1'b0, 3'd0, lcr_pkg::EV_NONE, 1'b0)),
         tx_exp(MODE_SPARE, 1'b1, 1'b1,
                outcome(lcr_pkg::PH_IDLE, 1'b0, 3'd0, lcr_pkg::EV_NONE, 1'b0)),
         tx_exp(lcr_pkg::MODE_END, 1'b0, 1'b1,
                outcome(lcr_pkg::PH_IDLE, 1'b0, 3'd0, lcr_pkg::EV_IDLE, 1'b1)),
         tx_exp(lcr_pkg::MODE_BEGIN, 1'b0, 1'b1,
                outcome(lcr_pkg::PH_ERROR, 1'b0, 3'd0, lcr_pkg::EV_ERROR, 1'b0)),
         tx_exp(lcr_pkg::MODE_TICK, 1'b0, 1'b1,
                outcome(lcr_pkg::PH_ERROR, 1'b0, 3'd0, lcr_pkg::EV_NONE, 1'b0)),
         tx_exp(lcr_pkg::MODE_BEGIN, 1'b1, 1'b1,
                outcome(lcr_pkg::PH_ERROR, 1'b0, 3'd0, lcr_pkg::EV_NONE, 1'b0)),
         tx_exp(lcr_pkg::MODE_END, 1'b1, 1'b1,
                outcome(lcr_pkg::PH_IDLE, 1'b0, 3'd0, lcr_pkg::EV_IDLE, 1'b1)),
         csr(lcr_pkg::REG_NETWORK_COUNT, 32'd2),
         csr(lcr_pkg::REG_RETRY_INTERVAL, 32'd1),
         csr(lcr_pkg::REG_MAX_RETRIES, 32'd1),
         tx_exp(lcr_pkg::MODE_BEGIN, 1'b0, 1'b1,
                outcome(lcr_pkg::PH_CONNECTING, 1'b0, 3'd0, lcr_pkg::EV_CONNECTING, 1'b0)),
         // Attempts rotate through both networks and wrap back to the first.
         tx(lcr_pkg::MODE_TICK, 1'b0),
         tx(lcr_pkg::MODE_TICK, 1'b0),
         tx(lcr_pkg::MODE_TICK, 1'b0),
         tx(lcr_pkg::MODE_TICK, 1'b0),
         tx(lcr_pkg::MODE_TICK, 1'b0),
         tx(lcr_pkg::MODE_BEGIN, 1'b0),
         tx(lcr_pkg::MODE_TICK, 1'b1),
         tx(lcr_pkg::MODE_TICK, 1'b1),
         tx(lcr_pkg::MODE_BEGIN, 1'b1),
         tx(MODE_SPARE, 1'b0),
         tx(lcr_pkg::MODE_TICK, 1'b0),
         // Networks removed while connecting: the next attempt goes to error.
         csr(lcr_pkg::REG_NETWORK_COUNT, 32'd0),
         tx(lcr_pkg::MODE_TICK, 1'b0),
         tx(lcr_pkg::MODE_END, 1'b0),
         csr(lcr_pkg::REG_NETWORK_COUNT, 32'd2),
         tx(lcr_pkg::MODE_BEGIN, 1'b0),
         tx(lcr_pkg::MODE_TICK, 1'b1),
         // Link lost with no networks left also ends in error.
         csr(lcr_pkg::REG_NETWORK_COUNT, 32'd0),
         tx(lcr_pkg::MODE_TICK, 1'b0),
         tx(lcr_pkg::MODE_END, 1'b0)
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].is_cfg) write_reg(script[i].csr_idx, script[i].value);
         else send_item(script[i].mode, script[i].up, script[i].typed, script[i].res);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_reg(lcr_pkg::REG_NETWORK_COUNT, phase_cfg[p][0]);
         write_reg(lcr_pkg::REG_RETRY_INTERVAL, phase_cfg[p][1]);
         write_reg(lcr_pkg::REG_MAX_RETRIES, phase_cfg[p][2]);
         case (p / 2)
            0: begin
               send_gap_pct = 7;
               recv_stall_pct = 55;
            end
            1: begin
               send_gap_pct = 55;
               recv_stall_pct = 7;
            end
            default: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (p == 0 && sent >= 40 && hold_requests == 0) hold_requests++;
            if (p == 0 && sent >= 100 && !paused) begin
               drain_results();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 15) begin
               send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, '0);
               sent++;
            end else begin
               // A session: begin, a run of ticks, and usually an end.
               send_item(lcr_pkg::MODE_BEGIN, 1'($urandom_range(1)), 1'b0, '0);
               sent++;
               len = $urandom_range(40, 4);
               repeat (len) begin
                  if (st_phase == lcr_pkg::PH_CONNECTED) up = ($urandom_range(99) < 90);
                  else up = ($urandom_range(99) < 6);
                  send_item(lcr_pkg::MODE_TICK, up, 1'b0, '0);
                  sent++;
               end
               if ($urandom_range(99) < 60) begin
                  send_item(lcr_pkg::MODE_END, 1'($urandom_range(1)), 1'b0, '0);
                  sent++;
               end
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (check_errors == 0 && csr_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
